// ===== design/srf_pkg.sv =====
// Shared types and constants for the short-range force and Verlet update block.
package srf_pkg;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_CNT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_R  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX    = 3'd4;

  localparam logic [CFG_W-1:0] RST_CUTOFF = 31'd167772;
  localparam logic [CFG_W-1:0] RST_MIN_R  = 31'd1678;
  localparam logic [CFG_W-1:0] RST_MASS   = 31'd167772;
  localparam logic [CFG_W-1:0] RST_DT     = 31'd8389;
  localparam logic [CFG_W-1:0] RST_BOX    = 31'd16777216;

  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] nbr_x;
    logic signed [31:0] nbr_y;
    logic               nbr_valid;
    logic               last_item;
  } srf_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
  } srf_out_t;

  typedef struct packed {
    logic                 start;
    logic [63:0]          num;
    logic [62:0]          den;
    logic [DIV_CNT_W-1:0] sft;
  } srf_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } srf_div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_CHK, S_SQX, S_SQY, S_CUT, S_MINS, S_SQRT,
    S_DQ, S_WQ, S_DB, S_WB, S_DC, S_WC,
    S_FXL, S_FXH, S_FXS, S_FYL, S_FYH, S_FYS, S_NEND,
    S_IAL, S_IAH, S_IAS, S_IP, S_IPS, S_OUT
  } srf_state_t;

endpackage

// ===== design/short_range_force_verlet_update.sv =====
// Top level: cutoff pair force accumulation and velocity Verlet update of one particle.
// A valid neighbor inside the cutoff passes through the bit-serial divider (three
// divisions of 64, 64+2*FRAC_BITS and 64+FRAC_BITS steps) and the 32-step square root;
// a far neighbor skips both.
// The last item then runs the integration, and the result waits for out_ready.
// Synchronous active-low reset restores the register defaults and clears both accumulators.
module short_range_force_verlet_update import srf_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srf_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [63:0]          ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [DIV_CNT_W-1:0] SFT_B  = DIV_CNT_W'(2 * FRAC_BITS);
  localparam logic [DIV_CNT_W-1:0] SFT_C  = DIV_CNT_W'(FRAC_BITS);

  // Shifted product of two split partials, truncated and saturated to 2^63 - 1.
  function automatic logic [62:0] mshift_sat(logic [63:0] hi, logic [63:0] lo);
    logic [95:0] p;
    logic [95:0] sh;
    p  = {hi, 32'd0} + {32'd0, lo};
    sh = p >> FRAC_BITS;
    return (|sh[95:63]) ? MAX63[62:0] : sh[62:0];
  endfunction

  function automatic logic signed [63:0] with_sign(logic [62:0] m, logic neg);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [63:0] sadd64(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] negsat32(logic signed [31:0] v);
    return (v == {1'b1, 31'd0}) ? {1'b0, {31{1'b1}}} : -v;
  endfunction

  srf_state_t         state_r, state_nxt;
  logic [CFG_W-1:0]   cut_r, cut_nxt, minr_r, minr_nxt, mass_r, mass_nxt;
  logic [CFG_W-1:0]   dt_r, dt_nxt, box_r, box_nxt;
  logic signed [63:0] accx_r, accx_nxt, accy_r, accy_nxt;
  srf_in_t            itm_r, itm_nxt;
  logic [32:0]        adx_r, adx_nxt, ady_r, ady_nxt;
  logic               sx_r, sx_nxt, sy_r, sy_nxt, neg_r, neg_nxt;
  logic [63:0]        pl_r, pl_nxt, ph_r, ph_nxt;
  logic [62:0]        r2_r, r2_nxt;
  logic [63:0]        sv_r, sv_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [63:0]        wk_r, wk_nxt;
  logic               axis_r, axis_nxt;
  logic signed [31:0] nv_r, nv_nxt;
  srf_out_t           out_r, out_nxt;
  logic               ov_r, ov_nxt;

  srf_div_req_t       div_req;
  srf_div_rsp_t       div_rsp;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mprod;

  // Datapath temporaries.
  logic signed [32:0] dxs, dys;
  logic [63:0]        r2s, r2c, sq_t;
  logic signed [63:0] acc_sel, ts, np, size, dpos;
  logic [63:0]        amag;
  logic [31:0]        nvmag;
  logic signed [31:0] vsel, psel, nvn;
  logic signed [64:0] vsum;
  logic [62:0]        fmag;

  srf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign acc_sel = axis_r ? accy_r : accx_r;
  assign amag    = acc_sel[63] ? (64'd0 - acc_sel) : acc_sel;
  assign nvmag   = nv_r[31] ? (32'd0 - nv_r) : nv_r;

  // The single 32 by 32 multiplier is shared by every product of the item.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX:   begin mul_a = adx_r[31:0]; mul_b = adx_r[31:0]; end
      S_SQY:   begin mul_a = ady_r[31:0]; mul_b = ady_r[31:0]; end
      S_CUT:   begin mul_a = {1'b0, cut_r}; mul_b = {1'b0, cut_r}; end
      S_MINS:  begin mul_a = {1'b0, minr_r}; mul_b = {1'b0, minr_r}; end
      S_FXL:   begin mul_a = wk_r[31:0]; mul_b = adx_r[31:0]; end
      S_FXH:   begin mul_a = wk_r[63:32]; mul_b = adx_r[31:0]; end
      S_FYL:   begin mul_a = wk_r[31:0]; mul_b = ady_r[31:0]; end
      S_FYH:   begin mul_a = wk_r[63:32]; mul_b = ady_r[31:0]; end
      S_IAL:   begin mul_a = amag[31:0]; mul_b = {1'b0, dt_r}; end
      S_IAH:   begin mul_a = amag[63:32]; mul_b = {1'b0, dt_r}; end
      S_IP:    begin mul_a = nvmag; mul_b = {1'b0, dt_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mprod = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    cut_nxt   = cut_r;
    minr_nxt  = minr_r;
    mass_nxt  = mass_r;
    dt_nxt    = dt_r;
    box_nxt   = box_r;
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    itm_nxt   = itm_r;
    adx_nxt   = adx_r;
    ady_nxt   = ady_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    neg_nxt   = neg_r;
    pl_nxt    = pl_r;
    ph_nxt    = ph_r;
    r2_nxt    = r2_r;
    sv_nxt    = sv_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    wk_nxt    = wk_r;
    axis_nxt  = axis_r;
    nv_nxt    = nv_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r;
    div_req   = '0;

    dxs  = {itm_r.nbr_x[31], itm_r.nbr_x} - {itm_r.pos_x[31], itm_r.pos_x};
    dys  = {itm_r.nbr_y[31], itm_r.nbr_y} - {itm_r.pos_y[31], itm_r.pos_y};
    r2s  = pl_r + ph_r;
    r2c  = ({1'b0, r2_r} < mprod) ? mprod : {1'b0, r2_r};
    sq_t = res_r + bit_r;
    fmag = mshift_sat(ph_r, pl_r);
    ts   = with_sign(fmag, acc_sel[63]);
    vsel = axis_r ? itm_r.vel_y : itm_r.vel_x;
    psel = axis_r ? itm_r.pos_y : itm_r.pos_x;
    vsum = {{33{vsel[31]}}, vsel} + {ts[63], ts};
    dpos = $signed(pl_r >> FRAC_BITS);
    np   = {{32{psel[31]}}, psel} + (nv_r[31] ? -dpos : dpos);
    size = $signed({33'd0, box_r});
    nvn  = nv_r;

    // Register writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_we) begin
      case (cfg_idx)
        REG_CUTOFF: cut_nxt  = cfg_wdata;
        REG_MIN_R:  minr_nxt = cfg_wdata;
        REG_MASS:   mass_nxt = cfg_wdata;
        REG_DT:     dt_nxt   = cfg_wdata;
        REG_BOX:    box_nxt  = cfg_wdata;
        default:    ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        axis_nxt = 1'b0;
        if (in_valid) begin
          itm_nxt = in_data;
          if (in_data.nbr_valid) state_nxt = S_DIFF;
          else if (in_data.last_item) state_nxt = S_IAL;
        end
      end
      S_DIFF: begin
        adx_nxt   = dxs[32] ? (33'd0 - dxs) : dxs;
        ady_nxt   = dys[32] ? (33'd0 - dys) : dys;
        sx_nxt    = dxs[32];
        sy_nxt    = dys[32];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (adx_r > {2'b00, cut_r} || ady_r > {2'b00, cut_r}) state_nxt = S_NEND;
        else state_nxt = S_SQX;
      end
      S_SQX: begin
        pl_nxt    = mprod;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        ph_nxt    = mprod;
        state_nxt = S_CUT;
      end
      S_CUT: begin
        r2_nxt = r2s[62:0];
        if (r2s > mprod) state_nxt = S_NEND;
        else state_nxt = S_MINS;
      end
      S_MINS: begin
        // Clamp the squared distance at the squared minimum radius; a zero result becomes one unit.
        if (r2c == 64'd0) r2c = 64'd1;
        r2_nxt    = r2c[62:0];
        sv_nxt    = r2c;
        res_nxt   = '0;
        bit_nxt   = 64'd1 << 62;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (bit_r == 64'd0) begin
          state_nxt = S_DQ;
        end else begin
          if (sv_r >= sq_t) begin
            sv_nxt  = sv_r - sq_t;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      S_DQ: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(cut_r) << FRAC_BITS;
        div_req.den   = res_r[62:0];
        div_req.sft   = '0;
        state_nxt     = S_WQ;
      end
      S_WQ: begin
        if (div_rsp.done) begin
          neg_nxt   = div_rsp.quo > ONE_FX;
          wk_nxt    = (div_rsp.quo > ONE_FX) ? (div_rsp.quo - ONE_FX)
                                             : (ONE_FX - div_rsp.quo);
          state_nxt = S_DB;
        end
      end
      S_DB: begin
        div_req.start = 1'b1;
        div_req.num   = wk_r;
        div_req.den   = r2_r;
        div_req.sft   = SFT_B;
        state_nxt     = S_WB;
      end
      S_WB: begin
        if (div_rsp.done) begin
          wk_nxt    = div_rsp.quo;
          state_nxt = S_DC;
        end
      end
      S_DC: begin
        div_req.start = 1'b1;
        div_req.num   = wk_r;
        div_req.den   = (mass_r == '0) ? 63'd1 : 63'(mass_r);
        div_req.sft   = SFT_C;
        state_nxt     = S_WC;
      end
      S_WC: begin
        if (div_rsp.done) begin
          wk_nxt    = div_rsp.quo;
          state_nxt = S_FXL;
        end
      end
      S_FXL: begin
        pl_nxt    = mprod;
        state_nxt = S_FXH;
      end
      S_FXH: begin
        ph_nxt    = mprod;
        state_nxt = S_FXS;
      end
      S_FXS: begin
        accx_nxt  = sadd64(accx_r, with_sign(fmag, neg_r ^ sx_r));
        state_nxt = S_FYL;
      end
      S_FYL: begin
        pl_nxt    = mprod;
        state_nxt = S_FYH;
      end
      S_FYH: begin
        ph_nxt    = mprod;
        state_nxt = S_FYS;
      end
      S_FYS: begin
        accy_nxt  = sadd64(accy_r, with_sign(fmag, neg_r ^ sy_r));
        state_nxt = S_NEND;
      end
      S_NEND: begin
        axis_nxt  = 1'b0;
        state_nxt = itm_r.last_item ? S_IAL : S_IDLE;
      end
      S_IAL: begin
        pl_nxt    = mprod;
        state_nxt = S_IAH;
      end
      S_IAH: begin
        ph_nxt    = mprod;
        state_nxt = S_IAS;
      end
      S_IAS: begin
        if (vsum > 65'sd2147483647) nv_nxt = {1'b0, {31{1'b1}}};
        else if (vsum < -65'sd2147483648) nv_nxt = {1'b1, 31'd0};
        else nv_nxt = vsum[31:0];
        state_nxt = S_IP;
      end
      S_IP: begin
        pl_nxt    = mprod;
        state_nxt = S_IPS;
      end
      S_IPS: begin
        // One reflection per axis, then a clamp into the box.
        if (np < 0) begin
          np  = -np;
          nvn = negsat32(nv_r);
        end else if (np > size) begin
          np  = (size <<< 1) - np;
          nvn = negsat32(nv_r);
        end
        if (np < 0) np = '0;
        if (np > size) np = size;
        if (!axis_r) begin
          out_nxt.new_x  = np[31:0];
          out_nxt.new_vx = nvn;
          accx_nxt       = '0;
          axis_nxt       = 1'b1;
          state_nxt      = S_IAL;
        end else begin
          out_nxt.new_y  = np[31:0];
          out_nxt.new_vy = nvn;
          accy_nxt       = '0;
          ov_nxt         = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          ov_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cut_r   <= RST_CUTOFF;
      minr_r  <= RST_MIN_R;
      mass_r  <= RST_MASS;
      dt_r    <= RST_DT;
      box_r   <= RST_BOX;
      accx_r  <= '0;
      accy_r  <= '0;
      axis_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cut_r   <= cut_nxt;
      minr_r  <= minr_nxt;
      mass_r  <= mass_nxt;
      dt_r    <= dt_nxt;
      box_r   <= box_nxt;
      accx_r  <= accx_nxt;
      accy_r  <= accy_nxt;
      axis_r  <= axis_nxt;
      ov_r    <= ov_nxt;
    end
    itm_r <= itm_nxt;
    adx_r <= adx_nxt;
    ady_r <= ady_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    neg_r <= neg_nxt;
    pl_r  <= pl_nxt;
    ph_r  <= ph_nxt;
    r2_r  <= r2_nxt;
    sv_r  <= sv_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    wk_r  <= wk_nxt;
    nv_r  <= nv_nxt;
    out_r <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // The block never offers a result while it takes a new transaction.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // Both accumulators are empty once a result has been delivered.
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (accx_r == '0 && accy_r == '0))
    else $error("accumulators not cleared after result");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WQ || state_r == S_WB || state_r == S_WC))
    else $error("divider finished outside a wait state");

  // The square root of a 63-bit value fits in 32 bits.
  a_sqrt_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && bit_r == '0) |-> (res_r[63:32] == '0))
    else $error("square root result too wide");

endmodule

// ===== design/srf_div.sv =====
// Bit-serial restoring divider: floor((num * 2^sft) / den), saturated to 2^63 - 1.
module srf_div import srf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  srf_div_req_t req,
  output srf_div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]          num_r, num_nxt;
  logic [63:0]          rem_r, rem_nxt;
  logic [63:0]          quo_r, quo_nxt;
  logic [62:0]          den_r, den_nxt;
  logic [63:0]          trial;
  logic [64:0]          diff;

  always_comb begin
    trial    = {rem_r[62:0], num_r[63]};
    diff     = {1'b0, trial} - {2'b00, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd64 + req.sft;
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so one bit always fits.
      num_nxt = {num_r[62:0], 1'b0};
      rem_nxt = diff[64] ? trial : diff[63:0];
      quo_nxt = {quo_r[62:0], ~diff[64]};
      ovf_nxt = ovf_r | quo_r[63];
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = (ovf_r || quo_r[63]) ? MAX63 : quo_r;

endmodule
